@@ hdl/rcpb_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpb_pkg
// Types and constants shared by the RC control packet builder modules.
// ----------------------------------------------------------------------------
package rcpb_pkg;

  localparam int unsigned PKT_LEN    = 16;
  localparam int unsigned BODY_LEN   = PKT_LEN - 1;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned QDEPTH     = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT  = 3'd0,
    REG_TX_ID   = 3'd1,
    REG_BIND_CH = 3'd2,
    REG_DATA_CH = 3'd3,
    REG_PT_THR  = 3'd4
  } rcpb_reg_e;

  // packet format codes
  localparam logic [2:0] FMT_BASIC   = 3'd0;
  localparam logic [2:0] FMT_ALT     = 3'd1;
  localparam logic [2:0] FMT_LED     = 3'd2;
  localparam logic [2:0] FMT_PANTILT = 3'd3;
  localparam logic [2:0] FMT_COMPACT = 3'd4;

  // aux flag bit positions
  localparam int unsigned AUX_FLIP  = 0;
  localparam int unsigned AUX_PIC   = 1;
  localparam int unsigned AUX_VID   = 2;
  localparam int unsigned AUX_HEAD  = 3;
  localparam int unsigned AUX_RTH   = 4;
  localparam int unsigned AUX_AFLIP = 5;
  localparam int unsigned AUX_LEDN  = 6;

  localparam logic [7:0] BYTE4_VAL    = 8'h40;
  localparam logic [7:0] TRIM_HEADLS  = 8'h40;
  localparam logic [7:0] BIND_B14     = 8'hC0;
  localparam logic [7:0] TRIM_MID     = 8'h7F;
  localparam logic [14:0] PT_THR_RST  = 15'd16383;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PKT_LEN - 1);

  typedef struct packed {
    logic [2:0]  fmt;
    logic [23:0] tx_id;
    logic [31:0] bind_ch;
    logic [31:0] data_ch;
    logic [14:0] pt_thr;
  } rcpb_cfg_t;

  typedef struct packed {
    logic [7:0]         throttle;
    logic [7:0]         rudder;
    logic [7:0]         elevator;
    logic [7:0]         aileron;
    logic signed [15:0] pan;
    logic signed [15:0] tilt;
    logic [6:0]         aux;
  } rcpb_tick_t;

  // one packet ready for serialization: bytes 0..14, channel, phase flag
  typedef struct packed {
    logic [BODY_LEN-1:0][7:0] body;
    logic [7:0]               chan;
    logic                     is_bind;
  } rcpb_desc_t;

  function automatic logic [7:0] trim_of(input logic [7:0] x);
    logic [7:0] t;
    t = x[7] ? x : 8'(TRIM_MID - x);
    return t >> 1;
  endfunction

endpackage

@@ hdl/rcpb_front.sv @@
// ----------------------------------------------------------------------------
// rcpb_front
// Tick sequencer: tracks phase, bind countdown, hop position and blink
// counter, and assembles the packet body for each tick that sends one.
// ----------------------------------------------------------------------------
module rcpb_front #(
  parameter int unsigned BIND_PACKETS = 150,
  parameter int unsigned HOP_CHANNELS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rcpb_pkg::rcpb_cfg_t cfg_i,
  input  logic                take_i,
  input  rcpb_pkg::rcpb_tick_t tick_i,
  output logic                push_o,
  output rcpb_pkg::rcpb_desc_t desc_o
);

  localparam int unsigned HopN = 2 * HOP_CHANNELS;
  localparam int unsigned HopW = (HopN > 1) ? $clog2(HopN) : 1;

  typedef enum logic [1:0] {PH_INIT, PH_BIND, PH_DATA} phase_e;

  phase_e          phase_q, phase_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [HopW-1:0] hop_q, hop_d;
  logic [7:0]      blink_q, blink_d;

  logic            build, bind_ph;
  logic [HopW+1:0] hop_wide;
  logic [1:0]      entry;
  logic [31:0]     table_sel;
  logic [6:0]      aux;
  logic [7:0]      pt_bits;
  logic [7:0]      b10, b11, b14;
  logic signed [16:0] pan17, tilt17, thr17;
  logic            pan_out, tilt_out, blink_on;

  assign aux     = tick_i.aux;
  assign bind_ph = (phase_q == PH_BIND);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    build   = 1'b0;
    if (take_i) begin
      unique case (phase_q)
        PH_INIT: phase_d = PH_BIND;
        PH_BIND: begin
          if (cnt_q == 8'd0) begin
            phase_d = PH_DATA;
          end else begin
            cnt_d = cnt_q - 8'd1;
            build = 1'b1;
          end
        end
        PH_DATA: build = 1'b1;
        default: phase_d = PH_INIT;
      endcase
    end
  end

  // hop channel: each entry serves two packets in a row
  assign hop_wide  = {2'b00, hop_q};
  assign entry     = hop_wide[2:1];
  assign table_sel = bind_ph ? cfg_i.bind_ch : cfg_i.data_ch;
  assign hop_d     = (hop_q == HopW'(HopN - 1)) ? '0 : hop_q + HopW'(1);

  // pan/tilt bits, gated by the blink counter after its increment
  assign blink_d  = blink_q + 8'd1;
  assign blink_on = blink_d[4];
  assign pan17    = 17'(tick_i.pan);
  assign tilt17   = 17'(tick_i.tilt);
  assign thr17    = {2'b00, cfg_i.pt_thr};
  assign pan_out  = (pan17 > thr17) || (pan17 < -thr17);
  assign tilt_out = (tilt17 > thr17) || (tilt17 < -thr17);

  always_comb begin
    pt_bits = 8'h00;
    if (blink_on && pan_out) begin
      pt_bits = tick_i.pan[15] ? 8'h08 : 8'h04;
    end
    if (blink_on && tilt_out) begin
      pt_bits = pt_bits + (tick_i.tilt[15] ? 8'h20 : 8'h10);
    end
  end

  always_comb begin
    b10 = 8'h00;
    b11 = 8'h00;
    b14 = 8'h00;
    unique case (cfg_i.fmt) inside
      rcpb_pkg::FMT_BASIC, rcpb_pkg::FMT_PANTILT, rcpb_pkg::FMT_COMPACT: begin
        b10 = ((cfg_i.fmt == rcpb_pkg::FMT_PANTILT) ? pt_bits : 8'h00)
              + {6'd0, aux[rcpb_pkg::AUX_RTH], aux[rcpb_pkg::AUX_HEAD]};
        b14 = {2'b00, aux[rcpb_pkg::AUX_LEDN], aux[rcpb_pkg::AUX_VID],
               aux[rcpb_pkg::AUX_PIC], 2'b00, aux[rcpb_pkg::AUX_FLIP]};
      end
      rcpb_pkg::FMT_ALT: begin
        b10 = {6'd0, aux[rcpb_pkg::AUX_LEDN], 1'b0};
        b11 = {7'd0, aux[rcpb_pkg::AUX_RTH]};
        b14 = {2'b00, aux[rcpb_pkg::AUX_HEAD], aux[rcpb_pkg::AUX_AFLIP], 1'b0,
               aux[rcpb_pkg::AUX_FLIP], 2'b10};
      end
      default: begin
        b10 = {4'b0001, 2'b00, aux[rcpb_pkg::AUX_LEDN], aux[rcpb_pkg::AUX_AFLIP]};
        b14 = {3'b000, aux[rcpb_pkg::AUX_VID], aux[rcpb_pkg::AUX_PIC],
               aux[rcpb_pkg::AUX_FLIP], 2'b10};
      end
    endcase
    if (bind_ph) begin
      b14 = rcpb_pkg::BIND_B14;
    end
  end

  always_comb begin
    desc_o.body[0]  = tick_i.throttle;
    desc_o.body[1]  = tick_i.rudder;
    desc_o.body[2]  = tick_i.elevator;
    desc_o.body[3]  = tick_i.aileron;
    desc_o.body[4]  = rcpb_pkg::BYTE4_VAL;
    desc_o.body[5]  = aux[rcpb_pkg::AUX_HEAD] ? rcpb_pkg::TRIM_HEADLS
                                              : rcpb_pkg::trim_of(tick_i.elevator);
    desc_o.body[6]  = aux[rcpb_pkg::AUX_HEAD] ? rcpb_pkg::TRIM_HEADLS
                                              : rcpb_pkg::trim_of(tick_i.aileron);
    desc_o.body[7]  = cfg_i.tx_id[23:16];
    desc_o.body[8]  = cfg_i.tx_id[15:8];
    desc_o.body[9]  = cfg_i.tx_id[7:0];
    desc_o.body[10] = b10;
    desc_o.body[11] = b11;
    desc_o.body[12] = 8'h00;
    desc_o.body[13] = 8'h00;
    desc_o.body[14] = b14;
    desc_o.chan     = table_sel[entry*8 +: 8];
    desc_o.is_bind  = bind_ph;
  end

  assign push_o = build;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_INIT;
      cnt_q   <= 8'(BIND_PACKETS);
      hop_q   <= '0;
      blink_q <= 8'd0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (build) begin
        hop_q <= hop_d;
        if (cfg_i.fmt == rcpb_pkg::FMT_PANTILT) begin
          blink_q <= blink_d;
        end
      end
    end
  end

endmodule

@@ hdl/rcpb_queue.sv @@
// ----------------------------------------------------------------------------
// rcpb_queue
// Short queue of packet descriptors between the sequencer and serializer.
// ----------------------------------------------------------------------------
module rcpb_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  rcpb_pkg::rcpb_desc_t wdata_i,
  input  logic                 rd_i,
  output rcpb_pkg::rcpb_desc_t rdata_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int unsigned PtrW = (rcpb_pkg::QDEPTH > 1) ? $clog2(rcpb_pkg::QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(rcpb_pkg::QDEPTH + 1);

  rcpb_pkg::rcpb_desc_t slot_q [rcpb_pkg::QDEPTH];
  logic [PtrW-1:0]      wptr_q, rptr_q;
  logic [CntW-1:0]      cnt_q;

  assign full_o  = (cnt_q == CntW'(rcpb_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slot_q[rptr_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(rcpb_pkg::QDEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (rd_i) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ hdl/rcpb_back.sv @@
// ----------------------------------------------------------------------------
// rcpb_back
// Serializer: sends one packet byte per cycle into an output register while
// a waiting byte does not stall it, running the sum checksum.
// ----------------------------------------------------------------------------
module rcpb_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      avail_i,
  input  rcpb_pkg::rcpb_desc_t      desc_i,
  output logic                      done_o,
  input  logic                      pop_i,
  output logic                      empty_o,
  output logic [7:0]                packet_byte_o,
  output logic [rcpb_pkg::IDX_W-1:0] byte_index_o,
  output logic [7:0]                rf_channel_o,
  output logic                      is_bind_o,
  output logic                      last_byte_o
);

  logic                       ov_q;
  logic [rcpb_pkg::IDX_W-1:0] idx_q;
  logic [7:0]                 sum_q;
  logic                       adv, at_last;
  logic [7:0]                 cur_byte;
  logic [7:0]                 byte_q;
  logic [rcpb_pkg::IDX_W-1:0] oidx_q;
  logic [7:0]                 chan_q;
  logic                       bind_q, last_q;

  assign adv     = avail_i && (!ov_q || pop_i);
  assign at_last = (idx_q == rcpb_pkg::LAST_IDX);
  assign done_o  = adv && at_last;

  always_comb begin
    if (at_last) begin
      cur_byte = sum_q;
    end else begin
      cur_byte = desc_i.body[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
      sum_q <= 8'd0;
    end else begin
      if (adv) begin
        ov_q <= 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
      if (adv) begin
        // wrap to byte zero and clear the sum after the checksum goes out
        idx_q <= at_last ? '0 : idx_q + rcpb_pkg::IDX_W'(1);
        sum_q <= at_last ? 8'd0 : sum_q + cur_byte;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      byte_q <= cur_byte;
      oidx_q <= idx_q;
      chan_q <= desc_i.chan;
      bind_q <= desc_i.is_bind;
      last_q <= at_last;
    end
  end

  assign empty_o       = !ov_q;
  assign packet_byte_o = byte_q;
  assign byte_index_o  = oidx_q;
  assign rf_channel_o  = chan_q;
  assign is_bind_o     = bind_q;
  assign last_byte_o   = last_q;

endmodule

@@ hdl/rc_control_packet_builder.sv @@
// ----------------------------------------------------------------------------
// rc_control_packet_builder
// Builds 16-byte bind and data packets of an RC transmitter link, one packet
// per sending tick, with a trailing 8-bit sum checksum.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  tick in   push_i / full_o    throttle, rudder, elevator, aileron, pan, tilt, aux
//  byte out  pop_i / empty_o    packet_byte, byte_index, rf_channel, is_bind, last_byte
//  config    cfg_valid_i/ready  cfg_index_i (3 bits), cfg_data_i (32 bits)
//
//  A packet tick yields 16 result bytes, one per cycle while pop_i takes them;
//  the serializer's single byte per cycle limits the sustained tick rate.
//  Silent ticks (first after reset, bind-to-data switch) produce no bytes.
//  A two-entry descriptor queue lets ticks enter while bytes are stalled.
//  Reset returns to the init phase with control and config registers reset.
// ----------------------------------------------------------------------------
module rc_control_packet_builder #(
  parameter int unsigned BIND_PACKETS = 150,
  parameter int unsigned HOP_CHANNELS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [7:0]                        throttle_i,
  input  logic [7:0]                        rudder_i,
  input  logic [7:0]                        elevator_i,
  input  logic [7:0]                        aileron_i,
  input  logic signed [15:0]                pan_value_i,
  input  logic signed [15:0]                tilt_value_i,
  input  logic [6:0]                        aux_flags_i,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic [7:0]                        packet_byte_o,
  output logic [3:0]                        byte_index_o,
  output logic [7:0]                        rf_channel_o,
  output logic                              is_bind_o,
  output logic                              last_byte_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rcpb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rcpb_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  rcpb_pkg::rcpb_cfg_t  cfg_q;
  rcpb_pkg::rcpb_tick_t tick;
  rcpb_pkg::rcpb_desc_t wdesc, rdesc;
  logic                 take, qpush, qfull, qempty, qpop;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt     <= rcpb_pkg::FMT_BASIC;
      cfg_q.tx_id   <= 24'd0;
      cfg_q.bind_ch <= 32'd0;
      cfg_q.data_ch <= 32'd0;
      cfg_q.pt_thr  <= rcpb_pkg::PT_THR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcpb_pkg::REG_FORMAT:  cfg_q.fmt     <= cfg_data_i[2:0];
        rcpb_pkg::REG_TX_ID:   cfg_q.tx_id   <= cfg_data_i[23:0];
        rcpb_pkg::REG_BIND_CH: cfg_q.bind_ch <= cfg_data_i;
        rcpb_pkg::REG_DATA_CH: cfg_q.data_ch <= cfg_data_i;
        rcpb_pkg::REG_PT_THR:  cfg_q.pt_thr  <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign full_o = qfull;
  assign take   = push_i && !qfull;

  assign tick.throttle = throttle_i;
  assign tick.rudder   = rudder_i;
  assign tick.elevator = elevator_i;
  assign tick.aileron  = aileron_i;
  assign tick.pan      = pan_value_i;
  assign tick.tilt     = tilt_value_i;
  assign tick.aux      = aux_flags_i;

  rcpb_front #(
    .BIND_PACKETS(BIND_PACKETS),
    .HOP_CHANNELS(HOP_CHANNELS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .take_i(take),
    .tick_i(tick),
    .push_o(qpush),
    .desc_o(wdesc)
  );

  rcpb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (qpush),
    .wdata_i(wdesc),
    .rd_i   (qpop),
    .rdata_o(rdesc),
    .full_o (qfull),
    .empty_o(qempty)
  );

  rcpb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (!qempty),
    .desc_i       (rdesc),
    .done_o       (qpop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .packet_byte_o(packet_byte_o),
    .byte_index_o (byte_index_o),
    .rf_channel_o (rf_channel_o),
    .is_bind_o    (is_bind_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

@@ hdl/rcpb_checker.sv @@
// ----------------------------------------------------------------------------
// rcpb_checker
// Port-level checks of the packet builder's result stream.
// ----------------------------------------------------------------------------
module rcpb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pop_i,
  input logic       empty_o,
  input logic [7:0] packet_byte_o,
  input logic [3:0] byte_index_o,
  input logic [7:0] rf_channel_o,
  input logic       is_bind_o,
  input logic       last_byte_o
);

  // last flag marks exactly the checksum position
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (last_byte_o == (byte_index_o == 4'd15)))
    else $error("last_byte does not match byte_index");

  // bytes of one packet follow in order
  a_idx_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && !last_byte_o) |=>
      (empty_o || byte_index_o == $past(byte_index_o) + 4'd1))
    else $error("byte_index skipped within a packet");

  // channel and phase flag hold over a packet
  a_pkt_attr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && !last_byte_o) |=>
      (empty_o || ($stable(rf_channel_o) && $stable(is_bind_o))))
    else $error("channel or phase changed inside a packet");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(packet_byte_o)))
    else $error("waiting result changed");

endmodule

bind rc_control_packet_builder rcpb_checker u_rcpb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pop_i        (pop_i),
  .empty_o      (empty_o),
  .packet_byte_o(packet_byte_o),
  .byte_index_o (byte_index_o),
  .rf_channel_o (rf_channel_o),
  .is_bind_o    (is_bind_o),
  .last_byte_o  (last_byte_o)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RC control packet builder. A queue-fed driver
// pushes stick ticks and a monitor pops packet bytes, both with random idle
// gaps, except in steady phases. Each accepted tick runs through a local model
// of the link phases, hop sequence and blink counter, and every popped byte is
// compared field by field with the oldest predicted byte. Registers change
// between drained phases, covering all format codes and threshold extremes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned BIND_TICKS    = 150;
  localparam int unsigned HOPS          = 4;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned MAX_REPORTS   = 40;
  // codes past the named formats decode like the LED format
  localparam logic [2:0]  FMT_SPARE     = 3'd5;
  localparam logic [2:0]  FMT_CODE_MAX  = 3'd7;

  typedef enum logic [1:0] {ST_INIT, ST_BIND, ST_DATA} link_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] index;
    logic [7:0] chan;
    logic       is_bind;
    logic       last;
  } pkt_byte_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            push_i      = 1'b0;
  logic                            pop_i       = 1'b0;
  logic                            cfg_valid_i = 1'b0;
  rcpb_pkg::rcpb_reg_e             cfg_index_i = rcpb_pkg::REG_FORMAT;
  logic [rcpb_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;
  rcpb_pkg::rcpb_tick_t            tick_drv    = '0;
  logic                            full_o, empty_o, cfg_ready_o;
  logic [7:0]                      packet_byte_o, rf_channel_o;
  logic [3:0]                      byte_index_o;
  logic                            is_bind_o, last_byte_o;

  // link model state
  rcpb_pkg::rcpb_cfg_t shadow_cfg;
  link_state_e         link_state;
  logic [7:0]          bind_left;
  int unsigned         hop_pos;
  logic [7:0]          blink_count;

  rcpb_pkg::rcpb_tick_t tick_queue[$];
  pkt_byte_t            packet_bytes_due[$];
  pkt_byte_t            want;

  int unsigned ticks_issued  = 0;
  int unsigned ticks_taken   = 0;
  int unsigned bytes_checked = 0;
  int unsigned bind_packets  = 0;
  int unsigned data_packets  = 0;
  int unsigned pt_packets    = 0;
  int unsigned writes_done   = 0;
  int unsigned err_count     = 0;
  int unsigned push_gap      = 0;
  int unsigned pop_stall     = 0;
  bit          no_gaps       = 1'b0;

  always #6 clk_i = ~clk_i;

  rc_control_packet_builder #(
    .BIND_PACKETS(BIND_TICKS),
    .HOP_CHANNELS(HOPS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_o       (full_o),
    .throttle_i   (tick_drv.throttle),
    .rudder_i     (tick_drv.rudder),
    .elevator_i   (tick_drv.elevator),
    .aileron_i    (tick_drv.aileron),
    .pan_value_i  (tick_drv.pan),
    .tilt_value_i (tick_drv.tilt),
    .aux_flags_i  (tick_drv.aux),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .packet_byte_o(packet_byte_o),
    .byte_index_o (byte_index_o),
    .rf_channel_o (rf_channel_o),
    .is_bind_o    (is_bind_o),
    .last_byte_o  (last_byte_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [7:0] stick_trim(logic [7:0] x);
    logic [7:0] t;
    t = x[7] ? x : 8'(rcpb_pkg::TRIM_MID - x);
    return t >> 1;
  endfunction

  // advance the link model by one tick and queue the bytes it sends
  function automatic void predict_tick(rcpb_pkg::rcpb_tick_t t);
    logic [7:0]  p [rcpb_pkg::PKT_LEN];
    logic [7:0]  sum, chan, pt;
    logic [31:0] chan_map;
    logic        bind_pkt;
    int          thr, pan_v, tilt_v;
    pkt_byte_t   b;
    if (link_state == ST_INIT) begin
      link_state = ST_BIND;
      return;
    end
    if (link_state == ST_BIND) begin
      if (bind_left == 0) begin
        link_state = ST_DATA;
        return;
      end
      bind_left--;
      bind_pkt = 1'b1;
      bind_packets++;
    end else begin
      bind_pkt = 1'b0;
      data_packets++;
    end

    p[0] = t.throttle;
    p[1] = t.rudder;
    p[2] = t.elevator;
    p[3] = t.aileron;
    p[4] = rcpb_pkg::BYTE4_VAL;
    p[5] = t.aux[rcpb_pkg::AUX_HEAD] ? rcpb_pkg::TRIM_HEADLS : stick_trim(t.elevator);
    p[6] = t.aux[rcpb_pkg::AUX_HEAD] ? rcpb_pkg::TRIM_HEADLS : stick_trim(t.aileron);
    p[7] = shadow_cfg.tx_id[23:16];
    p[8] = shadow_cfg.tx_id[15:8];
    p[9] = shadow_cfg.tx_id[7:0];
    for (int i = 10; i < 14; i++) p[i] = 8'h00;
    p[14] = rcpb_pkg::BIND_B14;

    case (shadow_cfg.fmt)
      rcpb_pkg::FMT_BASIC, rcpb_pkg::FMT_PANTILT, rcpb_pkg::FMT_COMPACT: begin
        pt = 8'h00;
        if (shadow_cfg.fmt == rcpb_pkg::FMT_PANTILT) begin
          // blink counter runs only for pan/tilt packets; send bits while bit 4 is set
          blink_count++;
          pt_packets++;
          thr    = int'(shadow_cfg.pt_thr);
          pan_v  = $signed(t.pan);
          tilt_v = $signed(t.tilt);
          if (blink_count[4] && (pan_v > thr || pan_v < -thr))
            pt = (pan_v < 0) ? 8'h08 : 8'h04;
          if (blink_count[4] && (tilt_v > thr || tilt_v < -thr))
            pt = pt + ((tilt_v < 0) ? 8'h20 : 8'h10);
        end
        p[10] = pt + {6'b0, t.aux[rcpb_pkg::AUX_RTH], t.aux[rcpb_pkg::AUX_HEAD]};
        if (!bind_pkt)
          p[14] = {2'b0, t.aux[rcpb_pkg::AUX_LEDN], t.aux[rcpb_pkg::AUX_VID],
                   t.aux[rcpb_pkg::AUX_PIC], 2'b0, t.aux[rcpb_pkg::AUX_FLIP]};
      end
      rcpb_pkg::FMT_ALT: begin
        p[10] = {6'b0, t.aux[rcpb_pkg::AUX_LEDN], 1'b0};
        p[11] = {7'b0, t.aux[rcpb_pkg::AUX_RTH]};
        if (!bind_pkt)
          p[14] = {2'b0, t.aux[rcpb_pkg::AUX_HEAD], t.aux[rcpb_pkg::AUX_AFLIP], 1'b0,
                   t.aux[rcpb_pkg::AUX_FLIP], 2'b10};
      end
      default: begin
        p[10] = {3'b0, 1'b1, 2'b0, t.aux[rcpb_pkg::AUX_LEDN],
                 t.aux[rcpb_pkg::AUX_AFLIP]};
        if (!bind_pkt)
          p[14] = {3'b0, t.aux[rcpb_pkg::AUX_VID], t.aux[rcpb_pkg::AUX_PIC],
                   t.aux[rcpb_pkg::AUX_FLIP], 2'b10};
      end
    endcase

    sum = 8'h00;
    for (int i = 0; i < rcpb_pkg::PKT_LEN - 1; i++) sum = sum + p[i];
    p[rcpb_pkg::PKT_LEN-1] = sum;

    // each hop entry serves two packets in a row
    chan_map = bind_pkt ? shadow_cfg.bind_ch : shadow_cfg.data_ch;
    chan     = chan_map[8 * ((hop_pos / 2) % 4) +: 8];
    hop_pos  = (hop_pos + 1) % (2 * HOPS);

    for (int i = 0; i < rcpb_pkg::PKT_LEN; i++) begin
      b.data    = p[i];
      b.index   = 4'(i);
      b.chan    = chan;
      b.is_bind = bind_pkt;
      b.last    = (i == rcpb_pkg::PKT_LEN - 1);
      packet_bytes_due.push_back(b);
    end
  endfunction

  // tick driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_o) begin
        predict_tick(tick_drv);
        ticks_taken++;
      end
      if (!push_i || !full_o) begin
        if (push_gap > 0) begin
          push_gap--;
          push_i <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          tick_drv <= tick_queue.pop_front();
          push_i   <= 1'b1;
          push_gap = idle_len();
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // byte monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop_i && !empty_o) begin
        if (packet_bytes_due.size() == 0) begin
          report_mismatch($sformatf("byte %02h at index %0d with no packet pending",
                                    packet_byte_o, byte_index_o));
        end else begin
          want = packet_bytes_due.pop_front();
          bytes_checked++;
          if (packet_byte_o !== want.data)
            report_mismatch($sformatf("packet_byte %02h, want %02h (index %0d)",
                                      packet_byte_o, want.data, want.index));
          if (byte_index_o !== want.index)
            report_mismatch($sformatf("byte_index %0d, want %0d", byte_index_o,
                                      want.index));
          if (rf_channel_o !== want.chan)
            report_mismatch($sformatf("rf_channel %02h, want %02h (index %0d)",
                                      rf_channel_o, want.chan, want.index));
          if (is_bind_o !== want.is_bind)
            report_mismatch($sformatf("is_bind %b, want %b (index %0d)", is_bind_o,
                                      want.is_bind, want.index));
          if (last_byte_o !== want.last)
            report_mismatch($sformatf("last_byte %b, want %b (index %0d)",
                                      last_byte_o, want.last, want.index));
        end
        pop_stall = idle_len();
      end
      if (pop_stall > 0) begin
        pop_stall--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  // leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_reg(rcpb_pkg::rcpb_reg_e idx, logic [31:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rcpb_pkg::REG_FORMAT:  shadow_cfg.fmt     = val[2:0];
      rcpb_pkg::REG_TX_ID:   shadow_cfg.tx_id   = val[23:0];
      rcpb_pkg::REG_BIND_CH: shadow_cfg.bind_ch = val;
      rcpb_pkg::REG_DATA_CH: shadow_cfg.data_ch = val;
      rcpb_pkg::REG_PT_THR:  shadow_cfg.pt_thr  = val[14:0];
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic queue_tick(logic [7:0] th, logic [7:0] ru, logic [7:0] el,
                            logic [7:0] ai, logic [15:0] pa, logic [15:0] ti,
                            logic [6:0] aux);
    rcpb_pkg::rcpb_tick_t t;
    t.throttle = th;
    t.rudder   = ru;
    t.elevator = el;
    t.aileron  = ai;
    t.pan      = pa;
    t.tilt     = ti;
    t.aux      = aux;
    tick_queue.push_back(t);
    ticks_issued++;
  endtask

  function automatic logic [15:0] axis_value();
    int thr;
    thr = int'(shadow_cfg.pt_thr);
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(thr);
      3: return 16'(-thr);
      4: return 16'(thr + 1);
      5: return 16'(-thr - 1);
      default: return 16'($urandom());
    endcase
  endfunction

  // wait for all ticks taken and all bytes popped, then let silent ticks settle
  task automatic drain();
    while (ticks_taken != ticks_issued || packet_bytes_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(logic [2:0] fmt, logic [23:0] id, logic [31:0] bind_ch,
                           logic [31:0] data_ch, logic [14:0] thr, int unsigned n,
                           bit steady);
    write_reg(rcpb_pkg::REG_FORMAT, 32'(fmt));
    write_reg(rcpb_pkg::REG_TX_ID, 32'(id));
    write_reg(rcpb_pkg::REG_BIND_CH, bind_ch);
    write_reg(rcpb_pkg::REG_DATA_CH, data_ch);
    write_reg(rcpb_pkg::REG_PT_THR, 32'(thr));
    cfg_valid_i <= 1'b0;
    no_gaps = steady;
    for (int unsigned i = 0; i < n; i++) begin
      queue_tick(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                 axis_value(), axis_value(), 7'($urandom_range(0, 127)));
    end
    drain();
  endtask

  initial begin
    link_state         = ST_INIT;
    bind_left          = 8'(BIND_TICKS);
    hop_pos            = 0;
    blink_count        = 8'h00;
    shadow_cfg         = '0;
    shadow_cfg.pt_thr  = rcpb_pkg::PT_THR_RST;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values; first tick is silent, then bind packets
    queue_tick(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 7'h00);
    queue_tick(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 7'h00);
    queue_tick(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h7FFF, 16'h7FFF, 7'h7F);
    queue_tick(8'h80, 8'h80, 8'h80, 8'h80, 16'h8000, 16'h8000, 7'h00);
    queue_tick(8'h7F, 8'h7F, 8'h7F, 8'h7F, 16'h0001, 16'hFFFF, 7'h00);
    queue_tick(8'h01, 8'h7E, 8'h81, 8'hFE, 16'h3FFF, 16'hC001, 7'h00);
    queue_tick(8'h00, 8'h00, 8'h00, 8'h00, 16'h4000, 16'hBFFF, 7'h00);
    for (int k = 0; k < 7; k++) begin
      queue_tick(8'(k * 37), 8'(8'hFF - k), 8'(k * 41), 8'(8'h80 + k), 16'h0000,
                 16'h0000, 7'(1 << k));
    end
    queue_tick(8'h55, 8'hAA, 8'h00, 8'hFF, 16'h0000, 16'h0000, 7'h7F);
    queue_tick(8'hAA, 8'h55, 8'hFF, 8'h00, 16'h0000, 16'h0000, 7'h77);
    drain();

    run_phase(rcpb_pkg::FMT_PANTILT, 24'hFFFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 15'd0,
              40, 1'b0);
    run_phase(rcpb_pkg::FMT_ALT, 24'($urandom()), $urandom(), $urandom(), 15'h7FFF, 30,
              1'b1);
    run_phase(rcpb_pkg::FMT_LED, 24'($urandom()), $urandom(), $urandom(),
              rcpb_pkg::PT_THR_RST, 30, 1'b0);
    // runs past the last bind packet and the switch-over tick
    run_phase(rcpb_pkg::FMT_COMPACT, 24'h000000, $urandom(), $urandom(),
              15'($urandom()), 40, 1'b0);
    run_phase(rcpb_pkg::FMT_PANTILT, 24'($urandom()), $urandom(), 32'hFFFF_FFFF, 15'd0,
              25, 1'b0);
    run_phase(rcpb_pkg::FMT_PANTILT, 24'($urandom()), $urandom(), $urandom(), 15'h7FFF,
              25, 1'b0);
    run_phase(rcpb_pkg::FMT_PANTILT, 24'($urandom()), $urandom(), $urandom(),
              15'($urandom_range(1, 32766)), 15, 1'b1);
    run_phase(rcpb_pkg::FMT_BASIC, 24'hFFFFFF, $urandom(), $urandom(),
              rcpb_pkg::PT_THR_RST, 25, 1'b0);
    run_phase(rcpb_pkg::FMT_ALT, 24'($urandom()), $urandom(), 32'h0000_0000,
              15'($urandom()), 25, 1'b0);
    run_phase(rcpb_pkg::FMT_LED, 24'($urandom()), $urandom(), $urandom(),
              15'($urandom()), 20, 1'b0);
    run_phase(rcpb_pkg::FMT_COMPACT, 24'($urandom()), $urandom(), $urandom(),
              15'($urandom()), 20, 1'b0);
    for (int f = FMT_SPARE; f <= FMT_CODE_MAX; f++) begin
      run_phase(3'(f), 24'($urandom()), $urandom(), $urandom(), 15'($urandom()), 10,
                1'b0);
    end

    $display("run: %0d ticks, %0d bind and %0d data packets (%0d pan/tilt), %0d bytes",
             ticks_taken, bind_packets, data_packets, pt_packets, bytes_checked);
    $display("run: %0d register writes over all format codes and threshold extremes",
             writes_done);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("run timed out with %0d ticks taken of %0d", ticks_taken, ticks_issued);
    $display("FAILURE");
    $finish;
  end

endmodule

@@ rc_control_packet_builder.f @@
hdl/rcpb_pkg.sv
hdl/rcpb_front.sv
hdl/rcpb_queue.sv
hdl/rcpb_back.sv
hdl/rc_control_packet_builder.sv
hdl/rcpb_checker.sv
tb/tb_top.sv
